### rtl/core/svt_pkg.sv
// Package: types, codes and default sizes for the sector validity tracker.
`default_nettype none
package svt_pkg;

  localparam int NUM_UNITS_DEF         = 32;
  localparam int CHUNKS_PER_UNIT_DEF   = 32;
  localparam int SECTORS_PER_CHUNK_DEF = 1024;

  localparam int UPG_W       = 6;
  localparam int RES_CNT_W   = 11;
  localparam int PU_RAW_W    = 11;
  localparam logic [UPG_W-1:0] UPG_RESET = 6'd4;

  localparam logic CMD_MARK_VALID   = 1'b0;
  localparam logic CMD_MARK_INVALID = 1'b1;

  typedef enum logic [1:0] {
    MARK_UNUSED  = 2'd0,
    MARK_VALID   = 2'd1,
    MARK_INVALID = 2'd2
  } svt_mark_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UNIT,
    S_CHUNK,
    S_SECTOR,
    S_READ,
    S_UPDATE
  } svt_state_t;

  typedef struct packed {
    logic       cmd;
    logic [4:0] unit_group;
    logic [4:0] unit_in_group;
    logic [4:0] chunk;
    logic [9:0] sector;
    logic       batch_end;
  } svt_req_t;

  typedef struct packed {
    svt_mark_t            prior_state;
    logic                 changed;
    logic [RES_CNT_W-1:0] valid_total;
    logic [RES_CNT_W-1:0] invalid_total;
    logic                 addr_error;
    logic                 batch_last;
  } svt_res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic calc_unit;
    logic calc_chunk;
    logic calc_sector;
    logic update;
  } svt_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;
  } svt_stat_t;

endpackage
`default_nettype wire

### rtl/core/svt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module svt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/svt_ctrl.sv
// Controller: sequences the clearing sweep and the per-request update steps.
`default_nettype none
module svt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire svt_pkg::svt_stat_t stat,
  output svt_pkg::svt_ctl_t      ctl,
  output logic                   busy,
  output logic                   done
);

  svt_pkg::svt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svt_pkg::S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == svt_pkg::S_UPDATE);
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      svt_pkg::S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = svt_pkg::S_IDLE;
        end
      end
      svt_pkg::S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = svt_pkg::S_UNIT;
        end
      end
      svt_pkg::S_UNIT: begin
        ctl.calc_unit = 1'b1;
        state_next    = svt_pkg::S_CHUNK;
      end
      svt_pkg::S_CHUNK: begin
        ctl.calc_chunk = 1'b1;
        state_next     = svt_pkg::S_SECTOR;
      end
      svt_pkg::S_SECTOR: begin
        ctl.calc_sector = 1'b1;
        state_next      = svt_pkg::S_READ;
      end
      // RAM read data lands at the end of this cycle
      svt_pkg::S_READ: begin
        state_next = svt_pkg::S_UPDATE;
      end
      svt_pkg::S_UPDATE: begin
        ctl.update = 1'b1;
        state_next = svt_pkg::S_IDLE;
      end
      default: begin
        state_next = svt_pkg::S_CLEAR;
      end
    endcase
  end

  assign busy = (state != svt_pkg::S_IDLE);

endmodule
`default_nettype wire

### rtl/core/svt_datapath.sv
// Datapath: address arithmetic, mark and counter RAMs, read-modify-write, result register.
`default_nettype none
module svt_datapath #(
  parameter int NUM_UNITS         = svt_pkg::NUM_UNITS_DEF,
  parameter int CHUNKS_PER_UNIT   = svt_pkg::CHUNKS_PER_UNIT_DEF,
  parameter int SECTORS_PER_CHUNK = svt_pkg::SECTORS_PER_CHUNK_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire svt_pkg::svt_ctl_t        ctl,
  output svt_pkg::svt_stat_t            stat,
  input  wire svt_pkg::svt_req_t        request,
  input  wire logic                     cfg_we,
  input  wire logic [svt_pkg::UPG_W-1:0] cfg_data,
  output svt_pkg::svt_res_t             result
);

  localparam int CHUNK_DEPTH = NUM_UNITS * CHUNKS_PER_UNIT;
  localparam int SECT_DEPTH  = CHUNK_DEPTH * SECTORS_PER_CHUNK;
  localparam int PU_W  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int CI_W  = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int SI_W  = (SECT_DEPTH > 1) ? $clog2(SECT_DEPTH) : 1;
  localparam int CNT_W = $clog2(SECTORS_PER_CHUNK + 1);

  svt_pkg::svt_req_t                req_q;
  logic [svt_pkg::UPG_W-1:0]        upg;
  logic [svt_pkg::PU_RAW_W-1:0]     pu;
  logic                             err;
  logic [CI_W-1:0]                  ci;
  logic [SI_W-1:0]                  si;
  logic [SI_W-1:0]                  clr_idx;

  logic [1:0]                       mark_rd;
  logic [2*CNT_W-1:0]               cnt_rd;
  logic                             mark_we;
  logic [SI_W-1:0]                  mark_waddr;
  logic [1:0]                       mark_wdata;
  logic                             cnt_we;
  logic [CI_W-1:0]                  cnt_waddr;
  logic [2*CNT_W-1:0]               cnt_wdata;

  svt_pkg::svt_mark_t               mark_prior;
  svt_pkg::svt_mark_t               mark_new;
  logic [CNT_W-1:0]                 v_cur, i_cur, v_new, i_new;
  logic                             chg;
  logic                             wr_ok;
  logic [31:0]                      v_ext, i_ext;
  logic                             clr_in_chunks;
  svt_pkg::svt_res_t                res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      upg     <= svt_pkg::UPG_RESET;
      clr_idx <= '0;
    end else begin
      if (cfg_we) begin
        upg <= cfg_data;
      end
      if (ctl.clear) begin
        clr_idx <= clr_idx + SI_W'(1);
      end
    end
  end

  assign stat.clear_done = (clr_idx == SI_W'(SECT_DEPTH - 1));
  assign clr_in_chunks   = (32'(clr_idx) < 32'(CHUNK_DEPTH));

  // Address arithmetic, one multiply per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= request;
    end
    if (ctl.calc_unit) begin
      pu <= svt_pkg::PU_RAW_W'(req_q.unit_group) * svt_pkg::PU_RAW_W'(upg)
            + svt_pkg::PU_RAW_W'(req_q.unit_in_group);
    end
    if (ctl.calc_chunk) begin
      err <= (32'(pu) >= 32'(NUM_UNITS)) || (32'(req_q.chunk) >= 32'(CHUNKS_PER_UNIT))
             || (32'(req_q.sector) >= 32'(SECTORS_PER_CHUNK));
      ci  <= CI_W'(pu[PU_W-1:0]) * CI_W'(CHUNKS_PER_UNIT) + CI_W'(req_q.chunk);
    end
    if (ctl.calc_sector) begin
      si <= SI_W'(ci) * SI_W'(SECTORS_PER_CHUNK) + SI_W'(req_q.sector);
    end
    if (ctl.update) begin
      result <= res_next;
    end
  end

  svt_ram #(.WIDTH(2), .DEPTH(SECT_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (si),
    .rdata (mark_rd)
  );

  svt_ram #(.WIDTH(2 * CNT_W), .DEPTH(CHUNK_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (ci),
    .rdata (cnt_rd)
  );

  assign mark_prior = svt_pkg::svt_mark_t'(mark_rd);
  assign v_cur      = cnt_rd[2*CNT_W-1:CNT_W];
  assign i_cur      = cnt_rd[CNT_W-1:0];

  always_comb begin
    v_new    = v_cur;
    i_new    = i_cur;
    mark_new = mark_prior;
    chg      = 1'b0;
    if (req_q.cmd == svt_pkg::CMD_MARK_VALID) begin
      case (mark_prior)
        svt_pkg::MARK_UNUSED: begin
          v_new    = v_cur + CNT_W'(1);
          mark_new = svt_pkg::MARK_VALID;
          chg      = 1'b1;
        end
        svt_pkg::MARK_INVALID: begin
          if (i_cur != '0) begin
            i_new = i_cur - CNT_W'(1);
          end
          v_new    = v_cur + CNT_W'(1);
          mark_new = svt_pkg::MARK_VALID;
          chg      = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (mark_prior == svt_pkg::MARK_VALID) begin
      if (v_cur != '0) begin
        v_new = v_cur - CNT_W'(1);
      end
      i_new    = i_cur + CNT_W'(1);
      mark_new = svt_pkg::MARK_INVALID;
      chg      = 1'b1;
    end
  end

  assign wr_ok = ctl.update && chg && !err;

  // Sweep takes the write ports while clearing
  always_comb begin
    if (ctl.clear) begin
      mark_we    = 1'b1;
      mark_waddr = clr_idx;
      mark_wdata = svt_pkg::MARK_UNUSED;
      cnt_we     = clr_in_chunks;
      cnt_waddr  = clr_idx[CI_W-1:0];
      cnt_wdata  = '0;
    end else begin
      mark_we    = wr_ok;
      mark_waddr = si;
      mark_wdata = mark_new;
      cnt_we     = wr_ok;
      cnt_waddr  = ci;
      cnt_wdata  = {v_new, i_new};
    end
  end

  assign v_ext = 32'(v_new);
  assign i_ext = 32'(i_new);

  always_comb begin
    res_next.prior_state   = err ? svt_pkg::MARK_UNUSED : mark_prior;
    res_next.changed       = chg && !err;
    res_next.valid_total   = err ? '0 : v_ext[svt_pkg::RES_CNT_W-1:0];
    res_next.invalid_total = err ? '0 : i_ext[svt_pkg::RES_CNT_W-1:0];
    res_next.addr_error    = err;
    res_next.batch_last    = req_q.batch_end;
  end

endmodule
`default_nettype wire

### rtl/core/sector_validity_tracker_top.sv
// Top level of the sector validity tracker: controller, datapath and checks.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   names a sector by group, unit in group, chunk and sector, and marks it
//   valid or invalid. One result per request appears on result for exactly
//   one cycle with done high; the receiver cannot stall it.
//   done rises once the controller has walked from the accepting edge
//   through three address steps (one multiply each), one RAM read and one
//   write-back; busy stays high until then, so requests do not overlap.
//   units_per_group is written with cfg_we/cfg_data while busy is low.
//   Reset: the mark and counter RAMs are swept to zero, one entry a cycle,
//   over NUM_UNITS*CHUNKS_PER_UNIT*SECTORS_PER_CHUNK entries (1048576 at the
//   defaults) with busy held high; config writes are still taken.
//   Out-of-range addresses return addr_error with zero totals and leave
//   all state untouched.
`default_nettype none
module sector_validity_tracker_top #(
  parameter int NUM_UNITS         = svt_pkg::NUM_UNITS_DEF,
  parameter int CHUNKS_PER_UNIT   = svt_pkg::CHUNKS_PER_UNIT_DEF,
  parameter int SECTORS_PER_CHUNK = svt_pkg::SECTORS_PER_CHUNK_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire svt_pkg::svt_req_t         request,
  output logic                           done,
  output svt_pkg::svt_res_t              result,
  input  wire logic                      cfg_we,
  input  wire logic [svt_pkg::UPG_W-1:0] cfg_data
);

  svt_pkg::svt_ctl_t  ctl;
  svt_pkg::svt_stat_t stat;

  svt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  svt_datapath #(
    .NUM_UNITS         (NUM_UNITS),
    .CHUNKS_PER_UNIT   (CHUNKS_PER_UNIT),
    .SECTORS_PER_CHUNK (SECTORS_PER_CHUNK)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepting a request");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_error_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && result.addr_error) |->
      (!result.changed && result.valid_total == '0 && result.invalid_total == '0))
    else $error("address error result carries an update");

  a_invalidate_counts: assert property (@(posedge clk) disable iff (rst)
    (done && result.changed && result.prior_state == svt_pkg::MARK_VALID) |->
      (result.invalid_total != '0))
    else $error("invalidation left the invalid count at zero");

endmodule
`default_nettype wire
